// ===== hw/rtl/ptest_pkg.sv =====
`timescale 1ns / 1ps
package ptest_pkg;

    localparam int unsigned TrialLimit = 997;
    localparam int unsigned BaseCount  = 6;
    localparam int unsigned BaseWidth  = 4;
    localparam int unsigned TrialWidth = 10;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_TRIAL,
        t_ST_TRIAL_WAIT,
        t_ST_SPLIT,
        t_ST_BASE,
        t_ST_POW_SQ,
        t_ST_POW_MUL,
        t_ST_POW_WAIT,
        t_ST_CHECK,
        t_ST_SQ,
        t_ST_SQ_WAIT,
        t_ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        t_MOP_MUL,
        t_MOP_REM
    } t_mop;

    typedef struct packed {
        logic start;
        t_mop op;
    } t_mreq;

    function automatic logic [BaseWidth-1:0] base_at(input logic [2:0] idx);
        logic [BaseWidth-1:0] b;
        b = 4'd2;
        case (idx)
            3'd0: b = 4'd2;
            3'd1: b = 4'd3;
            3'd2: b = 4'd5;
            3'd3: b = 4'd7;
            3'd4: b = 4'd11;
            3'd5: b = 4'd13;
            default: b = 4'd2;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/ptest_mulmod.sv =====
`timescale 1ns / 1ps
module ptest_mulmod
    import ptest_pkg::*;
#(
    parameter int unsigned W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mreq        i_req,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_res
);
    // MUL: x*y mod m, MSB-first double-and-add (x,y < m).
    // REM: x mod m, MSB-first bit-serial remainder.
    localparam int unsigned CW = $clog2(W + 1);

    logic         r_busy, n_busy;
    t_mop         r_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0] r_x, r_y, r_m, r_acc;
    logic         r_done;
    logic [W:0]   dbl, dbl_r, sum;
    logic [W-1:0] acc_d, acc_a;

    always_comb begin
        dbl   = {r_acc, 1'b0} | {{W{1'b0}}, (r_op == t_MOP_REM) ? r_x[W-1] : 1'b0};
        dbl_r = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        acc_d = dbl_r[W-1:0];
        sum   = {1'b0, acc_d} + {1'b0, r_y};
        acc_a = (sum >= {1'b0, r_m}) ? W'(sum - {1'b0, r_m}) : sum[W-1:0];
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= t_MOP_MUL;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= r_busy && (r_cnt == CW'(1)) && !i_req.start;
            if (i_req.start) begin
                r_op <= i_req.op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_op == t_MOP_MUL && r_x[W-1]) begin
                r_acc <= acc_a;
            end else begin
                r_acc <= acc_d;
            end
            r_x <= {r_x[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
endmodule

// ===== hw/rtl/primality_test_64bit.sv =====
`timescale 1ns / 1ps
// Work: trial division tries the integers 2..997 in turn, and each base costs W squarings
// plus up to W products and squarings, each done in the bit-serial multiplier.
// Throughput: one number at a time; busy drops in the cycle o_valid pulses, and a new
// transfer is taken from that cycle. o_valid is high for one cycle; the receiver cannot stall.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle.
module primality_test_64bit
    import ptest_pkg::*;
#(
    parameter int unsigned NUMBER_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_number,
    output logic        o_valid,
    output logic        o_is_prime
);
    localparam int unsigned W  = NUMBER_WIDTH;
    localparam int unsigned SW = $clog2(W);

    t_state r_state, n_state;
    logic [W-1:0] r_n, r_d, r_e, r_r, r_x, r_nm1;
    logic [SW-1:0] r_s, r_ri;
    logic [TrialWidth-1:0] r_t;
    logic [2:0] r_bi;
    logic r_prime;
    logic [SW:0] r_ecnt;

    t_mreq mreq;
    logic [W-1:0] m_x, m_y, m_m;
    logic m_done;
    logic [W-1:0] m_res;

    ptest_mulmod #(.W(W)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq),
        .i_x(m_x), .i_y(m_y), .i_m(m_m), .o_done(m_done), .o_res(m_res)
    );

    logic take;
    assign take = start && (r_state == t_ST_IDLE);
    assign busy = (r_state != t_ST_IDLE);

    always_comb begin
        n_state   = r_state;
        mreq.start = 1'b0;
        mreq.op    = t_MOP_MUL;
        m_x = r_x;
        m_y = r_x;
        m_m = r_n;
        case (r_state)
            t_ST_IDLE: if (start) n_state = t_ST_TRIAL;
            t_ST_TRIAL: begin
                if (r_n < W'(2)) begin
                    n_state = t_ST_DONE;
                end else if (r_t > TrialWidth'(TrialLimit)) begin
                    n_state = t_ST_SPLIT;
                end else if (r_n == W'(r_t)) begin
                    n_state = t_ST_DONE;
                end else begin
                    mreq.start = 1'b1;
                    mreq.op    = t_MOP_REM;
                    m_x = r_n;
                    m_m = W'(r_t);
                    n_state = t_ST_TRIAL_WAIT;
                end
            end
            t_ST_TRIAL_WAIT: if (m_done) n_state = (m_res == '0) ? t_ST_DONE : t_ST_TRIAL;
            t_ST_SPLIT: if (r_d[0]) n_state = t_ST_BASE;
            t_ST_BASE: n_state = (r_bi == 3'(BaseCount)) ? t_ST_DONE : t_ST_POW_MUL;
            t_ST_POW_MUL: begin
                if (r_ecnt == '0) begin
                    n_state = t_ST_CHECK;
                end else if (r_e[0]) begin
                    mreq.start = 1'b1;
                    m_x = r_r;
                    m_y = r_x;
                    n_state = t_ST_POW_WAIT;
                end else begin
                    n_state = t_ST_POW_SQ;
                end
            end
            t_ST_POW_WAIT: if (m_done) n_state = t_ST_POW_SQ;
            t_ST_POW_SQ: begin
                mreq.start = 1'b1;
                n_state = t_ST_SQ_WAIT;
            end
            t_ST_SQ_WAIT: if (m_done) n_state = t_ST_POW_MUL;
            t_ST_CHECK: begin
                if (r_r == W'(1) || r_r == r_nm1) begin
                    n_state = t_ST_BASE;
                end else if (r_ri >= r_s) begin
                    n_state = t_ST_DONE;
                end else begin
                    mreq.start = 1'b1;
                    m_x = r_r;
                    m_y = r_r;
                    n_state = t_ST_SQ;
                end
            end
            t_ST_SQ: if (m_done) begin
                if (m_res == r_nm1) begin
                    n_state = t_ST_BASE;
                end else if (r_ri + 1'b1 >= r_s) begin
                    n_state = t_ST_DONE;
                end else begin
                    mreq.start = 1'b1;
                    m_x = m_res;
                    m_y = m_res;
                end
            end
            t_ST_DONE: n_state = t_ST_IDLE;
            default: n_state = t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == t_ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            t_ST_IDLE: if (take) begin
                r_n     <= i_number[W-1:0];
                r_d     <= i_number[W-1:0] - W'(1);
                r_nm1   <= i_number[W-1:0] - W'(1);
                r_t     <= TrialWidth'(2);
                r_s     <= '0;
                r_bi    <= '0;
                r_prime <= 1'b0;
            end
            t_ST_TRIAL: begin
                if (r_n >= W'(2) && r_t <= TrialWidth'(TrialLimit) && r_n == W'(r_t))
                    r_prime <= 1'b1;
                r_x <= W'(r_t);
            end
            t_ST_TRIAL_WAIT: if (m_done) r_t <= r_t + 1'b1;
            t_ST_SPLIT: if (!r_d[0]) begin
                r_d <= r_d >> 1;
                r_s <= r_s + 1'b1;
            end
            t_ST_BASE: begin
                if (r_bi == 3'(BaseCount)) r_prime <= 1'b1;
                r_x    <= W'(base_at(r_bi));
                r_r    <= W'(1);
                r_e    <= r_d;
                r_ecnt <= (SW+1)'(W);
                r_ri   <= SW'(1);
                r_bi   <= r_bi + 1'b1;
            end
            t_ST_POW_WAIT: if (m_done) r_r <= m_res;
            t_ST_SQ_WAIT: if (m_done) begin
                r_x    <= m_res;
                r_e    <= r_e >> 1;
                r_ecnt <= r_ecnt - 1'b1;
            end
            t_ST_SQ: if (m_done) begin
                r_r  <= m_res;
                r_ri <= r_ri + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_is_prime = r_prime;
endmodule

// ===== hw/rtl/ptest_checker.sv =====
`timescale 1ns / 1ps
module ptest_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("no busy after transfer");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result longer than one cycle");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid) else $error("busy dropped without result");
endmodule

bind primality_test_64bit ptest_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_valid(o_valid)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import ptest_pkg::*;

    localparam int unsigned IdleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_number;
    logic        o_valid;
    logic        o_is_prime;

    bit          verdict_q[$];
    int unsigned errors;
    int unsigned quiet_cycles;

    primality_test_64bit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        x = x % m;
        y = y % m;
        while (x != 0) begin
            if (x[0]) begin
                acc = add_mod(acc, y, m);
            end
            x = x >> 1;
            y = add_mod(y, y, m);
        end
        return acc;
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] r;
        logic [63:0] x;
        r = 64'd1 % m;
        x = b % m;
        while (e != 0) begin
            if (e[0]) begin
                r = mul_mod(r, x, m);
            end
            x = mul_mod(x, x, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic bit predict_prime(logic [63:0] n);
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] x;
        int unsigned s;
        bit          witness;
        logic [63:0] bases [6];
        bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13};
        if (n < 2) begin
            return 1'b0;
        end
        for (int unsigned t = 2; t <= TrialLimit; t++) begin
            if (n == t) begin
                return 1'b1;
            end
            if (n % t == 0) begin
                return 1'b0;
            end
        end
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < BaseCount; i++) begin
            a = bases[i] % n;
            if (a == 0) begin
                continue;
            end
            x = pow_mod(a, d, n);
            if (x == 1 || x == n - 1) begin
                continue;
            end
            witness = 1'b1;
            for (int unsigned r = 1; r < s; r++) begin
                x = mul_mod(x, x, n);
                if (x == n - 1) begin
                    witness = 1'b0;
                    break;
                end
            end
            if (witness) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (verdict_q.size() == 0) begin
                $error("is_prime: unexpected result %0b", o_is_prime);
                errors++;
            end else begin
                bit exp_v;
                exp_v = verdict_q.pop_front();
                if (o_is_prime !== exp_v) begin
                    $error("is_prime: expected %0b, actual %0b", exp_v, o_is_prime);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IdleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_number(logic [63:0] v);
        start    <= 1'b1;
        i_number <= v;
        do begin
            @(posedge i_clk);
        end while (busy);
        verdict_q.push_back(predict_prime(v));
    endtask

    task automatic pause_sender();
        int unsigned n;
        if ($urandom_range(0, 2) == 0) begin
            return;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [63:0] vals [$];
        vals = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd991, 64'd997, 64'd998,
                 64'd1009, 64'd1022117, 64'd1000003, 64'd3215031751,
                 64'd3474749660383, 64'd4294967291 * 64'd4294967291,
                 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 64'h8000_0000_0000_001D,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB};
        foreach (vals[i]) begin
            send_number(vals[i]);
            pause_sender();
        end
    endtask

    task automatic test_drain_pause();
        start <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        send_number({$urandom, $urandom} | 64'd1);
    endtask

    task automatic test_random();
        logic [63:0] v;
        for (int i = 0; i < 100; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: v = {$urandom, $urandom};
                3, 4, 5, 6: v = {$urandom, $urandom} | 64'h8000_0000_0000_0001;
                7: v = {32'd0, $urandom} | 64'd1;
                default: v = 64'($urandom_range(0, 1 << 20));
            endcase
            send_number(v);
            if (i < 30) begin
                pause_sender();
            end else if (i >= 70) begin
                pause_sender();
            end
        end
    endtask

    initial begin
        errors   = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_number = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_pause();
        test_random();
        start <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
